// File: sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key-value cache modules.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_WIDTH       = 5;

   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   localparam logic signed [31:0] READ_MISS = -32'sd1;

   typedef struct packed {
      logic               func;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic match;
      logic commit;
   } cmd_type;

endpackage

// File: sv/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: capture, match, commit; owns the handshake valid/stall state.
// ----------------------------------------------------------------------------
module lkvc_ctrl
   import lkvc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      commit;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   assign cmd.capture = accept;
   assign cmd.match   = (state_ff == ST_MATCH);
   assign cmd.commit  = commit;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry store, parallel key match, recency ranks and result register.
// ----------------------------------------------------------------------------
module lkvc_datapath
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  req_type              req_payload,
   input  logic                 csr_we,
   input  logic [CAP_WIDTH-1:0] csr_wdata,
   output rsp_type              rsp_payload
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = IW;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int XW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

   typedef enum logic [2:0] {
      ACT_GET_HIT,
      ACT_GET_MISS,
      ACT_PUT_HIT,
      ACT_FILL,
      ACT_EVICT
   } act_type;

   logic [ENTRIES-1:0]   valid_ff;
   logic signed [31:0]   key_ff  [ENTRIES];
   logic signed [31:0]   data_ff [ENTRIES];
   logic [RW-1:0]        rank_ff [ENTRIES];
   logic [CW-1:0]        fill_ff;
   logic [CAP_WIDTH-1:0] cap_ff;
   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;

   act_type              act_ff, act_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic [CW-1:0]        old_rank_ff, old_rank_in;

   logic                 hit_found;
   logic [IW-1:0]        hit_idx, free_idx, lru_idx;
   logic [RW-1:0]        lru_rank;
   logic [XW-1:0]        cap_x, eff_cap;
   logic                 fill_ok;

   // capacity clamp and free-room test
   always_comb begin
      cap_x = XW'(cap_ff);
      if (cap_x == '0) begin
         eff_cap = XW'(1);
      end else if (cap_x > XW'(ENTRIES)) begin
         eff_cap = XW'(ENTRIES);
      end else begin
         eff_cap = cap_x;
      end
      fill_ok = XW'(fill_ff) < eff_cap;
   end

   // lowest matching, lowest free and least recent slots
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      free_idx  = '0;
      lru_idx   = '0;
      lru_rank  = RW'(fill_ff - CW'(1));
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_ff.key) begin
            hit_found = 1'b1;
            hit_idx   = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
         if (valid_ff[i] && rank_ff[i] == lru_rank) begin
            lru_idx = IW'(i);
         end
      end
   end

   always_comb begin
      act_in      = ACT_GET_MISS;
      slot_in     = hit_idx;
      old_rank_in = CW'(rank_ff[hit_idx]);
      if (req_ff.func == FUNC_GET) begin
         act_in = hit_found ? ACT_GET_HIT : ACT_GET_MISS;
      end else if (hit_found) begin
         act_in = ACT_PUT_HIT;
      end else if (fill_ok) begin
         act_in      = ACT_FILL;
         slot_in     = free_idx;
         old_rank_in = fill_ff + CW'(1);
      end else begin
         act_in      = ACT_EVICT;
         slot_in     = lru_idx;
         old_rank_in = CW'(lru_rank);
      end
   end

   always_comb begin
      rsp_in.hit         = (act_ff == ACT_GET_HIT) || (act_ff == ACT_PUT_HIT);
      rsp_in.evicted     = (act_ff == ACT_EVICT);
      rsp_in.read_value  = '0;
      rsp_in.evicted_key = '0;
      case (act_ff)
         ACT_GET_HIT:  rsp_in.read_value  = data_ff[slot_ff];
         ACT_GET_MISS: rsp_in.read_value  = READ_MISS;
         ACT_EVICT:    rsp_in.evicted_key = key_ff[slot_ff];
         default:      rsp_in.read_value  = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         cap_ff   <= CAPACITY_RESET;
      end else begin
         if (csr_we) cap_ff <= csr_wdata;
         if (cmd.commit && act_ff == ACT_FILL) begin
            valid_ff[slot_ff] <= 1'b1;
            fill_ff           <= fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
      if (cmd.match) begin
         act_ff      <= act_in;
         slot_ff     <= slot_in;
         old_rank_ff <= old_rank_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         if (act_ff == ACT_FILL || act_ff == ACT_EVICT) begin
            key_ff[slot_ff] <= req_ff.key;
         end
         if (act_ff == ACT_FILL || act_ff == ACT_EVICT || act_ff == ACT_PUT_HIT) begin
            data_ff[slot_ff] <= req_ff.value;
         end
      end
   end

   // recency update: entries more recent than the touched one age by one
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.commit && act_ff != ACT_GET_MISS) begin
            if (IW'(i) == slot_ff) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && CW'(rank_ff[i]) < old_rank_ff) begin
               rank_ff[i] <= rank_ff[i] + RW'(1);
            end
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: sv/lru_key_value_cache.sv
// A taken request passes the match and update states; its result is registered at commit.
// No new request is taken until that commit (capture, match, commit sequence).
// The parallel key match over all entries sets the match cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset: synchronous; clears all entries, the fill count and sets capacity to 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CAP_WIDTH-1:0] csr_wdata
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
   import lkvc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   a_evict_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.evicted |-> !rsp_payload.hit && rsp_payload.read_value == '0)
      else $error("eviction reported with hit or read data");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.evicted |-> rsp_payload.evicted_key == '0)
      else $error("evicted key not zero without eviction");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
